[rtl/base64_stream_decoder_core_macros.svh]
// assertion macros used by the decoder checker
`ifndef BASE64_STREAM_DECODER_CORE_MACROS_SVH
`define BASE64_STREAM_DECODER_CORE_MACROS_SVH

// same-cycle implication, ignored while reset is asserted
`define B64D_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, ignored while reset is asserted
`define B64D_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

// next-cycle implication that also holds across reset
`define B64D_ASSERT_ALWAYS(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/b64d_pkg.sv]
// package with types, constants and decode functions of the base64 decoder
`timescale 1ns / 1ps

package b64d_pkg;

    localparam logic [7:0] CharPad   = 8'h3D;
    localparam logic [7:0] CharPlus  = 8'h2B;
    localparam logic [7:0] CharSlash = 8'h2F;
    localparam logic [7:0] CharUpA   = 8'h41;
    localparam logic [7:0] CharUpZ   = 8'h5A;
    localparam logic [7:0] CharLoA   = 8'h61;
    localparam logic [7:0] CharLoZ   = 8'h7A;
    localparam logic [7:0] CharDig0  = 8'h30;
    localparam logic [7:0] CharDig9  = 8'h39;

    localparam logic [5:0] SextetPlus  = 6'd62;
    localparam logic [5:0] SextetSlash = 6'd63;
    localparam logic [5:0] SextetLoA   = 6'd26;
    localparam logic [5:0] SextetDig0  = 6'd52;
    // non-alphabet characters carry all ones in the low bits, as the 0xff code does
    localparam logic [5:0] SextetBad   = 6'h3F;

    localparam int unsigned BytesPerQuad = 3;
    localparam int unsigned MaxResults   = 2 * BytesPerQuad;
    localparam int unsigned CountW       = $clog2(MaxResults + 1);

    typedef struct packed {
        logic       bad;
        logic [5:0] val;
    } t_sextet;

    // one request worth of results, drained one per cycle unless the output stalls
    typedef struct packed {
        logic              rel;      // first three results come from word_a
        logic [CountW-1:0] total;    // number of results, at least one
        logic [23:0]       word_a;   // released quad
        logic [23:0]       word_b;   // held quad flushed at message end
        logic              eom;      // last result ends the message
        logic              bare;     // single end marker without data
        logic              bad;      // end marker flags an invalid message
    } t_bundle;

    function automatic t_sextet decode_char(input logic [7:0] c);
        t_sextet s;
        s.bad = 1'b0;
        s.val = 6'd0;
        if (c >= CharUpA && c <= CharUpZ) begin
            s.val = 6'(c - CharUpA);
        end else if (c >= CharLoA && c <= CharLoZ) begin
            s.val = 6'(c - CharLoA) + SextetLoA;
        end else if (c >= CharDig0 && c <= CharDig9) begin
            s.val = 6'(c - CharDig0) + SextetDig0;
        end else if (c == CharPlus) begin
            s.val = SextetPlus;
        end else if (c == CharSlash) begin
            s.val = SextetSlash;
        end else if (c == CharPad) begin
            s.val = 6'd0;
        end else begin
            s.bad = 1'b1;
            s.val = SextetBad;
        end
        return s;
    endfunction

    // byte k of a quad word, first byte highest
    function automatic logic [7:0] quad_byte(input logic [23:0] w, input logic [1:0] k);
        logic [7:0] b;
        unique case (k)
            2'd0:    b = w[23:16];
            2'd1:    b = w[15:8];
            2'd2:    b = w[7:0];
            default: b = 8'd0;
        endcase
        return b;
    endfunction

endpackage

[rtl/b64d_if.sv]
// valid/ready channel interfaces for the character and byte streams
`timescale 1ns / 1ps

interface b64d_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_char;
    logic       in_last;

    modport source (output valid, output in_char, output in_last, input ready);
    modport sink   (input valid, input in_char, input in_last, output ready);
endinterface

interface b64d_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       byte_valid;
    logic       bad_input;
    logic       end_of_message;

    modport source (output valid, output out_byte, output byte_valid,
                    output bad_input, output end_of_message, input ready);
    modport sink   (input valid, input out_byte, input byte_valid,
                    input bad_input, input end_of_message, output ready);
endinterface

[rtl/b64d_serializer.sv]
// result serializer: holds one bundle and emits its results through an output register
`timescale 1ns / 1ps

module b64d_serializer (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_load,
    input  b64d_pkg::t_bundle  i_bundle,
    output logic               o_free,
    b64d_out_if.source         o_out
);

    logic                            r_bv;
    logic [b64d_pkg::CountW-1:0]     r_idx;
    b64d_pkg::t_bundle               r_b;
    logic                            r_ov;
    logic [7:0]                      r_byte;
    logic                            r_byte_valid;
    logic                            r_bad;
    logic                            r_eom;

    logic                            out_free;
    logic                            take;
    logic                            last_elem;
    logic [b64d_pkg::CountW-1:0]     sub_idx;
    logic [7:0]                      e_byte;
    logic                            e_byte_valid;
    logic                            e_bad;
    logic                            e_eom;

    assign out_free  = !r_ov || o_out.ready;
    assign take      = r_bv && out_free;
    assign last_elem = (r_idx == r_b.total - 1'b1);
    assign o_free    = !r_bv || (take && last_elem);

    // element selection for the current index
    always_comb begin
        sub_idx      = r_idx - b64d_pkg::CountW'(b64d_pkg::BytesPerQuad);
        e_byte       = 8'd0;
        e_byte_valid = 1'b0;
        e_bad        = 1'b0;
        e_eom        = 1'b1;
        if (r_b.bare) begin
            e_bad = r_b.bad;
        end else begin
            e_byte_valid = 1'b1;
            e_eom        = r_b.eom && last_elem;
            if (r_b.rel && r_idx < b64d_pkg::CountW'(b64d_pkg::BytesPerQuad)) begin
                e_byte = b64d_pkg::quad_byte(r_b.word_a, r_idx[1:0]);
            end else if (r_b.rel) begin
                e_byte = b64d_pkg::quad_byte(r_b.word_b, sub_idx[1:0]);
            end else begin
                e_byte = b64d_pkg::quad_byte(r_b.word_b, r_idx[1:0]);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bv  <= 1'b0;
            r_idx <= '0;
            r_ov  <= 1'b0;
        end else begin
            if (take) begin
                r_ov <= 1'b1;
            end else if (o_out.ready) begin
                r_ov <= 1'b0;
            end
            if (i_load) begin
                r_bv  <= 1'b1;
                r_idx <= '0;
            end else if (take && last_elem) begin
                r_bv <= 1'b0;
            end else if (take) begin
                r_idx <= r_idx + 1'b1;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_b <= i_bundle;
        end
        if (take) begin
            r_byte       <= e_byte;
            r_byte_valid <= e_byte_valid;
            r_bad        <= e_bad;
            r_eom        <= e_eom;
        end
    end

    assign o_out.valid          = r_ov;
    assign o_out.out_byte       = r_byte;
    assign o_out.byte_valid     = r_byte_valid;
    assign o_out.bad_input      = r_bad;
    assign o_out.end_of_message = r_eom;

endmodule

[rtl/base64_stream_decoder_core.sv]
// top level of the streaming base64 decoder
`timescale 1ns / 1ps

// streaming base64 decoder, standard alphabet, '=' decodes as zero
// i_in: one character per request with in_last marking the end of a message
// o_out: one decoded byte per request; the last request of a message carries
//   end_of_message, and a message with no bytes or with a bad quad ends with a
//   bare marker (byte_valid low, bad_input set when an invalid quad was seen)
// each complete quad is held back until the next quad or the message end, so a
//   character produces 0 to 6 results
// the first result of a character is loaded into the result buffer when the
//   character is taken, and moves from there to the output register
// one character per cycle while the result buffer is empty; a character with
//   results holds the buffer and moves them out one result per cycle unless
//   the output stalls, and i_in.ready stays low until its last result moves
//   to the output register
// the result buffer and the output register let the next character in while
//   the last result of the previous one still waits for the receiver
// a stalled receiver holds the output register, then the buffer, then i_in.ready
// reset clears the quad state and drops any buffered results
module base64_stream_decoder_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    b64d_in_if.sink     i_in,
    b64d_out_if.source  o_out
);

    // quad assembly state
    logic [1:0]  r_cnt;
    logic [17:0] r_partial;
    logic        r_pinv;
    logic [23:0] r_held;
    logic        r_hv;
    logic        r_err;
    logic        r_prev_pad;

    logic [1:0]  n_cnt;
    logic [17:0] n_partial;
    logic        n_pinv;
    logic [23:0] n_held;
    logic        n_hv;
    logic        n_err;
    logic        n_prev_pad;

    b64d_pkg::t_sextet s;
    b64d_pkg::t_bundle bnd;
    logic              is_pad;
    logic              rel;
    logic              quad_bad;
    logic [1:0]        fin;
    logic              accept;
    logic              ser_free;

    assign accept     = i_in.valid && ser_free;
    assign i_in.ready = ser_free;

    always_comb begin
        s        = b64d_pkg::decode_char(i_in.in_char);
        is_pad   = (i_in.in_char == b64d_pkg::CharPad);
        quad_bad = r_pinv || s.bad;
        rel      = 1'b0;
        fin      = 2'd0;

        n_cnt      = r_cnt;
        n_partial  = r_partial;
        n_pinv     = r_pinv;
        n_held     = r_held;
        n_hv       = r_hv;
        n_err      = r_err;
        n_prev_pad = is_pad;

        if (r_cnt == 2'd3) begin
            // fourth character closes the quad
            n_cnt     = 2'd0;
            n_partial = 18'd0;
            n_pinv    = 1'b0;
            if (quad_bad) begin
                n_err = 1'b1;
                n_hv  = 1'b0;
            end else if (!r_err) begin
                rel    = r_hv;
                n_held = {r_partial, s.val};
                n_hv   = 1'b1;
            end
        end else begin
            n_partial = {r_partial[11:0], s.val};
            n_pinv    = r_pinv || s.bad;
            n_cnt     = r_cnt + 2'd1;
        end

        bnd.rel    = rel;
        bnd.word_a = r_held;
        bnd.word_b = n_held;
        bnd.eom    = i_in.in_last;
        bnd.bare   = 1'b0;
        bnd.bad    = 1'b0;
        bnd.total  = rel ? b64d_pkg::CountW'(b64d_pkg::BytesPerQuad) : '0;

        if (i_in.in_last) begin
            if (n_err) begin
                bnd.bare  = 1'b1;
                bnd.bad   = 1'b1;
                bnd.total = b64d_pkg::CountW'(1);
            end else begin
                // each pad among the last two characters drops one byte
                if (n_hv) begin
                    fin = 2'd3 - {1'b0, r_prev_pad} - {1'b0, is_pad};
                end
                bnd.total = bnd.total + b64d_pkg::CountW'(fin);
                if (bnd.total == '0) begin
                    bnd.bare  = 1'b1;
                    bnd.total = b64d_pkg::CountW'(1);
                end
            end
            // message end returns the state to its reset value
            n_cnt      = 2'd0;
            n_partial  = 18'd0;
            n_pinv     = 1'b0;
            n_held     = 24'd0;
            n_hv       = 1'b0;
            n_err      = 1'b0;
            n_prev_pad = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt      <= 2'd0;
            r_partial  <= 18'd0;
            r_pinv     <= 1'b0;
            r_held     <= 24'd0;
            r_hv       <= 1'b0;
            r_err      <= 1'b0;
            r_prev_pad <= 1'b0;
        end else if (accept) begin
            r_cnt      <= n_cnt;
            r_partial  <= n_partial;
            r_pinv     <= n_pinv;
            r_held     <= n_held;
            r_hv       <= n_hv;
            r_err      <= n_err;
            r_prev_pad <= n_prev_pad;
        end
    end

    b64d_serializer u_ser (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_load   (accept && (bnd.total != '0)),
        .i_bundle (bnd),
        .o_free   (ser_free),
        .o_out    (o_out)
    );

endmodule

[rtl/b64d_checker.sv]
// port-level checker for the base64 decoder and its bind
`timescale 1ns / 1ps
`include "base64_stream_decoder_core_macros.svh"

module b64d_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_out_valid,
    input logic       i_out_ready,
    input logic [7:0] i_out_byte,
    input logic       i_byte_valid,
    input logic       i_bad_input,
    input logic       i_eom
);

    `B64D_ASSERT_ALWAYS(a_rst_clears_out, !i_rst_n, !i_out_valid, "output valid after reset")
    `B64D_ASSERT_NEXT(a_stall_holds, i_out_valid && !i_out_ready,
        i_out_valid && $stable(i_out_byte) && $stable(i_byte_valid) && $stable(i_eom),
        "stalled output request changed")
    `B64D_ASSERT_NOW(a_bare_is_end, i_out_valid && !i_byte_valid,
        i_eom && i_out_byte == 8'd0, "bare marker without end of message")
    `B64D_ASSERT_NOW(a_bad_is_bare, i_out_valid && i_bad_input,
        !i_byte_valid && i_eom, "bad input flag on a data byte")

endmodule

bind base64_stream_decoder_core b64d_checker u_b64d_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_out_valid  (o_out.valid),
    .i_out_ready  (o_out.ready),
    .i_out_byte   (o_out.out_byte),
    .i_byte_valid (o_out.byte_valid),
    .i_bad_input  (o_out.bad_input),
    .i_eom        (o_out.end_of_message)
);

[tb/sv/base64_stream_decoder_core_tb.sv]
// self-checking testbench for the streaming base64 decoder core
`timescale 1ns / 1ps

module base64_stream_decoder_core_tb;

    typedef struct packed {
        logic [7:0] ch;
        logic       last;
    } t_char_req;

    typedef struct packed {
        logic [7:0] data;
        logic       byte_valid;
        logic       bad_input;
        logic       eom;
    } t_dec_result;

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;

    // request side, driven only through these registers
    logic       tx_valid = 1'b0;
    logic [7:0] tx_char  = 8'd0;
    logic       tx_last  = 1'b0;
    // result side
    logic       rx_ready = 1'b0;
    logic       rx_hold  = 1'b0;

    b64d_in_if  char_if ();
    b64d_out_if byte_if ();

    assign char_if.valid   = tx_valid;
    assign char_if.in_char = tx_char;
    assign char_if.in_last = tx_last;
    assign byte_if.ready   = rx_ready;

    base64_stream_decoder_core DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (char_if),
        .o_out   (byte_if)
    );

    t_char_req   char_q[$];     // characters still to be sent
    t_dec_result decoded_q[$];  // decoded bytes and end markers still due

    int unsigned chars_taken  = 0;
    int unsigned msgs_ended   = 0;
    int unsigned msgs_flagged = 0;
    int unsigned bytes_seen   = 0;
    int unsigned mismatches   = 0;
    int unsigned tx_idle      = 0;
    int unsigned tx_run       = 0;
    int unsigned rx_stall     = 0;
    int unsigned rx_run       = 0;

    // decoder state mirror
    logic [1:0]  quad_cnt  = 2'd0;
    logic [17:0] quad_bits = 18'd0;
    logic        quad_bad  = 1'b0;
    logic [23:0] held_word = 24'd0;
    logic        held_ok   = 1'b0;
    logic        msg_err   = 1'b0;
    logic        last_pad  = 1'b0;

    initial forever #1 i_clk = ~i_clk;

    // bit 6 flags a character outside the alphabet, low bits carry the sextet
    function automatic logic [6:0] sextet_lookup(input logic [7:0] c);
        if (c >= b64d_pkg::CharUpA && c <= b64d_pkg::CharUpZ)
            return {1'b0, 6'(c - b64d_pkg::CharUpA)};
        if (c >= b64d_pkg::CharLoA && c <= b64d_pkg::CharLoZ)
            return {1'b0, 6'(c - b64d_pkg::CharLoA + 8'd26)};
        if (c >= b64d_pkg::CharDig0 && c <= b64d_pkg::CharDig9)
            return {1'b0, 6'(c - b64d_pkg::CharDig0 + 8'd52)};
        if (c == b64d_pkg::CharPlus) return {1'b0, b64d_pkg::SextetPlus};
        if (c == b64d_pkg::CharSlash) return {1'b0, b64d_pkg::SextetSlash};
        if (c == b64d_pkg::CharPad) return 7'd0;
        return 7'h7F;
    endfunction

    function automatic logic [7:0] alpha_char(input logic [5:0] v);
        if (v < 6'd26) return b64d_pkg::CharUpA + 8'(v);
        if (v < 6'd52) return b64d_pkg::CharLoA + 8'(v - 6'd26);
        if (v < 6'd62) return b64d_pkg::CharDig0 + 8'(v - 6'd52);
        if (v == b64d_pkg::SextetPlus) return b64d_pkg::CharPlus;
        return b64d_pkg::CharSlash;
    endfunction

    function automatic logic [7:0] junk_char();
        logic [7:0] c;
        logic [6:0] sx;
        do begin
            c  = 8'($urandom_range(0, 255));
            sx = sextet_lookup(c);
        end while (!sx[6]);
        return c;
    endfunction

    // mostly back to back, some short gaps, a few long ones, and runs of none
    function automatic int unsigned draw_gap(inout int unsigned run);
        int unsigned r;
        if (run > 0) begin
            run--;
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 4) begin
            run = $urandom_range(15, 40);
            return 0;
        end
        if (r < 55) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(6, 25);
    endfunction

    task automatic push_bytes(input logic [23:0] word, input int unsigned n, input logic eom);
        for (int unsigned i = 0; i < n; i++)
            decoded_q.push_back('{8'(word >> (16 - 8 * i)), 1'b1, 1'b0, eom && (i == n - 1)});
    endtask

    task automatic decode_char(input logic [7:0] ch, input logic last);
        logic [6:0]  sx;
        logic        is_pad;
        logic        bad_quad;
        int unsigned n;
        sx     = sextet_lookup(ch);
        is_pad = (ch == b64d_pkg::CharPad);
        if (quad_cnt == 2'd3) begin
            bad_quad  = quad_bad | sx[6];
            // a bad quad also drops whatever quad was held
            if (bad_quad) begin
                msg_err = 1'b1;
                held_ok = 1'b0;
            end else if (!msg_err) begin
                if (held_ok) push_bytes(held_word, 3, 1'b0);
                held_word = {quad_bits, sx[5:0]};
                held_ok   = 1'b1;
            end
            quad_cnt  = 2'd0;
            quad_bits = 18'd0;
            quad_bad  = 1'b0;
        end else begin
            quad_bits = {quad_bits[11:0], sx[5:0]};
            quad_bad  = quad_bad | sx[6];
            quad_cnt  = quad_cnt + 2'd1;
        end
        if (!last) begin
            last_pad = is_pad;
        end else begin
            if (msg_err) begin
                decoded_q.push_back('{8'd0, 1'b0, 1'b1, 1'b1});
            end else if (held_ok) begin
                // one byte fewer per pad among the last two characters
                n = 3 - int'(last_pad) - int'(is_pad);
                push_bytes(held_word, n, 1'b1);
            end else begin
                decoded_q.push_back('{8'd0, 1'b0, 1'b0, 1'b1});
            end
            quad_cnt  = 2'd0;
            quad_bits = 18'd0;
            quad_bad  = 1'b0;
            held_word = 24'd0;
            held_ok   = 1'b0;
            msg_err   = 1'b0;
            last_pad  = 1'b0;
        end
    endtask

    task automatic add_text(input string s, input logic ends);
        for (int i = 0; i < s.len(); i++)
            char_q.push_back('{8'(s[i]), ends && (i == s.len() - 1)});
    endtask

    task automatic add_random_msg();
        t_char_req   msg[$];
        int unsigned nq;
        int unsigned kind;
        logic [7:0]  c;
        nq   = $urandom_range(0, 4);
        kind = $urandom_range(0, 99);
        for (int unsigned i = 0; i < nq * 4; i++) begin
            // an occasional pad inside the message decodes as zero
            c = ($urandom_range(0, 19) == 0) ? b64d_pkg::CharPad
                                             : alpha_char(6'($urandom_range(0, 63)));
            msg.push_back('{c, 1'b0});
        end
        if (kind < 60) begin
            if (nq > 0)
                for (int unsigned i = 0; i < $urandom_range(0, 2); i++)
                    msg[msg.size() - 1 - i].ch = b64d_pkg::CharPad;
        end else if (kind < 75) begin
            // trailing partial quad
            repeat ($urandom_range(1, 3)) begin
                c = ($urandom_range(0, 3) == 0) ? b64d_pkg::CharPad
                                                : alpha_char(6'($urandom_range(0, 63)));
                msg.push_back('{c, 1'b0});
            end
        end else if (kind < 85) begin
            if (msg.size() == 0)
                repeat (4) msg.push_back('{alpha_char(6'($urandom_range(0, 63))), 1'b0});
            msg[$urandom_range(0, msg.size() - 1)].ch = junk_char();
        end else begin
            repeat ($urandom_range(1, 8)) msg.push_back('{8'($urandom_range(0, 255)), 1'b0});
        end
        if (msg.size() == 0) msg.push_back('{alpha_char(6'($urandom_range(0, 63))), 1'b0});
        msg[msg.size() - 1].last = 1'b1;
        foreach (msg[i]) char_q.push_back(msg[i]);
    endtask

    task automatic check_field(input string field, input logic [7:0] want_v, got_v);
        if (got_v !== want_v) begin
            $error("%s: expected %0h, got %0h", field, want_v, got_v);
            mismatches++;
        end
    endtask

    // request driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            tx_valid <= 1'b0;
        end else begin
            if (char_if.valid && char_if.ready) begin
                decode_char(char_if.in_char, char_if.in_last);
                void'(char_q.pop_front());
                chars_taken++;
            end
            // a request not yet taken stays on the bus unchanged
            if (!(char_if.valid && !char_if.ready)) begin
                if (tx_idle > 0) begin
                    tx_idle--;
                    tx_valid <= 1'b0;
                end else if (char_q.size() > 0) begin
                    tx_valid <= 1'b1;
                    tx_char  <= char_q[0].ch;
                    tx_last  <= char_q[0].last;
                    tx_idle = draw_gap(tx_run);
                end else begin
                    tx_valid <= 1'b0;
                end
            end
        end
    end

    // result monitor and receiver stalls
    always @(posedge i_clk) begin
        t_dec_result want;
        if (!i_rst_n) begin
            rx_ready <= 1'b0;
        end else begin
            if (byte_if.valid && byte_if.ready) begin
                if (decoded_q.size() == 0) begin
                    $error("result with nothing due: out_byte %0h byte_valid %0b eom %0b",
                           byte_if.out_byte, byte_if.byte_valid, byte_if.end_of_message);
                    mismatches++;
                end else begin
                    want = decoded_q.pop_front();
                    check_field("out_byte", want.data, byte_if.out_byte);
                    check_field("byte_valid", 8'(want.byte_valid), 8'(byte_if.byte_valid));
                    check_field("bad_input", 8'(want.bad_input), 8'(byte_if.bad_input));
                    check_field("end_of_message", 8'(want.eom), 8'(byte_if.end_of_message));
                end
                if (byte_if.byte_valid) bytes_seen++;
                if (byte_if.end_of_message) msgs_ended++;
                if (byte_if.bad_input) msgs_flagged++;
                rx_stall = draw_gap(rx_run);
            end
            if (rx_stall > 0) begin
                rx_stall--;
                rx_ready <= 1'b0;
            end else begin
                rx_ready <= !rx_hold;
            end
        end
    end

    // one long receiver hold-off so the core backs up into its input
    initial begin
        wait (chars_taken >= 100);
        @(posedge i_clk);
        rx_hold <= 1'b1;
        repeat (120) @(posedge i_clk);
        rx_hold <= 1'b0;
    end

    initial begin
        #600000;
        $display("FAILURE");
        $finish;
    end

    initial begin
        // flush of a held quad at the end
        add_text("+/9zAZa0", 1'b1);
        // two pads at the end leave one byte
        add_text("TQ==", 1'b1);
        // quad with characters outside the alphabet
        char_q.push_back('{8'hFF, 1'b0});
        char_q.push_back('{8'h00, 1'b0});
        add_text("AB", 1'b1);
        // lone pad, no bytes at all
        add_text("=", 1'b1);
        // pads inside the message, then a trailing partial quad
        add_text("TQ==TWFuRA", 1'b1);
        while (char_q.size() < 260) add_random_msg();

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (char_q.size() != 0) @(posedge i_clk);
        while (decoded_q.size() != 0) @(posedge i_clk);
        repeat (10) @(posedge i_clk);

        $display("decoded %0d messages from %0d characters, %0d flagged bad",
                 msgs_ended, chars_taken, msgs_flagged);
        $display("%0d data bytes checked under random gaps and one long output stall",
                 bytes_seen);
        if (mismatches == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule

[filelist.f]
+incdir+rtl
rtl/b64d_pkg.sv
rtl/b64d_if.sv
rtl/b64d_serializer.sv
rtl/base64_stream_decoder_core.sv
rtl/b64d_checker.sv
tb/sv/base64_stream_decoder_core_tb.sv
